>>> rtl/ndab_pkg.sv
// ----------------------------------------------------------------------------
// ndab_pkg
// Shared constants of the n-gram double-array backoff lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ndab_pkg;
	localparam logic [1:0] ACT_ENTRY  = 2'd0;
	localparam logic [1:0] ACT_OFFSET = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [1:0] REG_BASE_COUNT  = 2'd0;
	localparam logic [1:0] REG_CHECK_COUNT = 2'd1;
	localparam logic [1:0] REG_BOW_COUNT   = 2'd2;

	localparam int CFG_W = 17;
	localparam logic [33:0] NO_ENTRY = 34'd1000000000;
	localparam int IR_BIT = 31;
endpackage
`default_nettype wire

>>> rtl/ngram_double_array_backoff_lookup_unit.sv
// ----------------------------------------------------------------------------
// ngram_double_array_backoff_lookup_unit
// Double-array trie n-gram scorer with backoff accumulation.
// ----------------------------------------------------------------------------
// Write and non-final query transfers leave the unit idle.
// A final query word starts two walks of up to ORDER and ORDER-1 trie levels,
// each level stepped by dependent offset/base/check reads.
// One query in flight at a time; a result waits in the output register while the
// next query is accepted. Reset clears control state and count registers only.
`default_nettype none
module ngram_double_array_backoff_lookup_unit #(
	parameter int TABLE_DEPTH = 65536,
	parameter int VOCAB_SIZE  = 65536,
	parameter int ORDER       = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// action[1:0], entry_addr[17:2], base_val[49:18], check_val[81:50],
	// prob_val[113:82], bow_val[145:114], offset_val[175:146], query_word[191:176]
	input  wire logic [191:0] s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// score[31:0], matched_len[35:32]
	output logic [39:0]       m_tdata,
	// overflow
	output logic              m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [16:0]  cfg_wdata
);
	import ndab_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int VW  = $clog2(VOCAB_SIZE);
	localparam int OW  = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int CW  = $clog2(ORDER + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_OFF, ST_OFFW, ST_CHK, ST_CHKW, ST_EVAL, ST_NODE,
		ST_NODEW, ST_DONE
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] base_cnt_q, check_cnt_q, bow_cnt_q;
	logic [15:0] words_q [ORDER];
	logic [CW-1:0] wcount_q;
	logic over_q;
	logic walk2_q;
	logic [CW-1:0] idx_q;
	logic [CW:0] level_q;
	logic signed [33:0] base_q;
	logic [33:0] pos_q, next_q;
	logic signed [31:0] prob_q;
	logic signed [40:0] bow_q;
	logic [31:0] chk_word_q;

	logic [1:0] action;
	logic [15:0] entry_addr, query_word;
	logic [31:0] base_val, check_val, prob_val, bow_val;
	logic [29:0] offset_val;
	assign action     = s_tdata[1:0];
	assign entry_addr = s_tdata[17:2];
	assign base_val   = s_tdata[49:18];
	assign check_val  = s_tdata[81:50];
	assign prob_val   = s_tdata[113:82];
	assign bow_val    = s_tdata[145:114];
	assign offset_val = s_tdata[175:146];
	assign query_word = s_tdata[191:176];

	logic xfer;
	assign s_tready = (state_q == ST_IDLE);
	assign xfer = s_tvalid && s_tready;

	logic [33:0] ccnt, bcnt, wcnt;
	assign ccnt = ({17'd0, check_cnt_q} > 34'(TABLE_DEPTH)) ? 34'(TABLE_DEPTH)
		: {17'd0, check_cnt_q};
	assign bcnt = ({17'd0, base_cnt_q} > 34'(TABLE_DEPTH)) ? 34'(TABLE_DEPTH)
		: {17'd0, base_cnt_q};
	assign wcnt = ({17'd0, bow_cnt_q} > 34'(TABLE_DEPTH)) ? 34'(TABLE_DEPTH)
		: {17'd0, bow_cnt_q};

	logic ent_we, off_we;
	assign ent_we = xfer && action == ACT_ENTRY && {16'd0, entry_addr} < 32'(TABLE_DEPTH);
	assign off_we = xfer && action == ACT_OFFSET && {16'd0, entry_addr} < 32'(VOCAB_SIZE);

	logic [AW-1:0] t_raddr;
	logic [VW-1:0] o_raddr;
	logic [31:0] base_rd, check_rd, prob_rd, bow_rd;
	logic [29:0] off_rd;
	logic [15:0] cur_word;
	assign cur_word = words_q[idx_q[OW-1:0]];
	assign o_raddr = VW'(cur_word);

	ndab_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_base (.clk, .we(ent_we),
		.waddr(AW'(entry_addr)), .wdata(base_val), .raddr(t_raddr), .rdata(base_rd));
	ndab_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_check (.clk, .we(ent_we),
		.waddr(AW'(entry_addr)), .wdata(check_val), .raddr(t_raddr), .rdata(check_rd));
	ndab_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_prob (.clk, .we(ent_we),
		.waddr(AW'(entry_addr)), .wdata(prob_val), .raddr(t_raddr), .rdata(prob_rd));
	ndab_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_bow (.clk, .we(ent_we),
		.waddr(AW'(entry_addr)), .wdata(bow_val), .raddr(t_raddr), .rdata(bow_rd));
	ndab_ram #(.WIDTH(30), .DEPTH(VOCAB_SIZE)) u_off (.clk, .we(off_we),
		.waddr(VW'(entry_addr)), .wdata(offset_val), .raddr(o_raddr), .rdata(off_rd));

	always_comb begin
		unique case (state_q)
			ST_START: t_raddr = '0;
			ST_CHK:   t_raddr = next_q[AW-1:0];
			default:  t_raddr = pos_q[AW-1:0];
		endcase
	end

	// base value as it comes out of memory, sentinel past the count
	logic signed [33:0] base_eff;
	assign base_eff = (pos_q < bcnt) ? 34'(signed'(base_rd)) : signed'(NO_ENTRY);

	logic [33:0] child;
	logic [33:0] word_off;
	assign word_off = ({16'd0, cur_word} < 32'(VOCAB_SIZE)) ? {4'd0, off_rd} : NO_ENTRY;
	assign child = base_q[33] ? (34'(-base_q) + word_off) : (34'(base_q) + {18'd0, cur_word});

	logic step_ok;
	assign step_ok = (next_q < ccnt) && (!walk2_q || next_q < bcnt)
		&& ({3'd0, chk_word_q[30:0]} == pos_q);

	logic signed [41:0] sum;
	logic signed [31:0] score;
	assign sum = 42'(prob_q) + 42'(bow_q);
	always_comb begin
		if (sum > 42'sd2147483647) score = 32'h7fffffff;
		else if (sum < -42'sd2147483648) score = 32'h80000000;
		else score = sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_cnt_q <= '0;
			check_cnt_q <= '0;
			bow_cnt_q  <= '0;
			wcount_q   <= '0;
			over_q     <= 1'b0;
			m_tvalid   <= 1'b0;
			walk2_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_BASE_COUNT:  base_cnt_q  <= cfg_wdata;
					REG_CHECK_COUNT: check_cnt_q <= cfg_wdata;
					REG_BOW_COUNT:   bow_cnt_q   <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (xfer && action == ACT_QUERY) begin
						if (wcount_q < CW'(ORDER)) begin
							words_q[wcount_q[OW-1:0]] <= query_word;
							wcount_q <= wcount_q + 1'b1;
						end else begin
							over_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_START;
							walk2_q <= 1'b0;
							idx_q   <= '0;
							level_q <= '0;
							prob_q  <= '0;
							bow_q   <= '0;
							pos_q   <= '0;
						end
					end
				end
				ST_START: begin
					state_q <= ST_OFF;
				end
				ST_OFF: begin
					base_q <= base_eff;
					if (walk2_q && wcount_q < 2) state_q <= ST_DONE;
					else if (idx_q >= wcount_q) state_q <= walk2_q ? ST_DONE : ST_START;
					else state_q <= ST_OFFW;
					if (!walk2_q && idx_q >= wcount_q) begin
						walk2_q <= 1'b1;
						idx_q   <= CW'(1);
						pos_q   <= '0;
					end
				end
				ST_OFFW: begin
					next_q  <= child;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= ST_CHKW;
				end
				ST_CHKW: begin
					chk_word_q <= check_rd;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!step_ok) begin
						if (walk2_q) state_q <= ST_DONE;
						else begin
							state_q <= ST_START;
							walk2_q <= 1'b1;
							idx_q   <= CW'(1);
							pos_q   <= '0;
						end
					end else begin
						pos_q   <= next_q;
						state_q <= ST_NODE;
					end
				end
				ST_NODE: begin
					state_q <= ST_NODEW;
				end
				ST_NODEW: begin
					base_q <= base_eff;
					if (!walk2_q) begin
						level_q <= (CW+1)'(idx_q) + 1'b1;
						if (signed'(prob_rd) > 0) begin
							prob_q  <= -signed'(prob_rd);
							state_q <= ST_START;
							walk2_q <= 1'b1;
							idx_q   <= CW'(1);
							pos_q   <= '0;
						end else begin
							prob_q  <= signed'(prob_rd);
							state_q <= (idx_q + 1'b1 >= wcount_q) ? ST_START : ST_OFF;
							if (idx_q + 1'b1 >= wcount_q) begin
								walk2_q <= 1'b1;
								idx_q   <= CW'(1);
								pos_q   <= '0;
							end else begin
								idx_q   <= idx_q + 1'b1;
							end
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						if ((CW+1)'(idx_q) >= level_q && !chk_word_q[IR_BIT] && pos_q < wcnt)
							bow_q <= bow_q + 41'(signed'(bow_rd));
						state_q <= (idx_q + 1'b1 >= wcount_q) ? ST_DONE : ST_OFF;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {4'd0, 4'(level_q), score};
						m_tuser  <= over_q;
						m_tvalid <= 1'b1;
						wcount_q <= '0;
						over_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) wcount_q <= CW'(ORDER))
		else $error("word count past order");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("held result changed");
endmodule
`default_nettype wire

>>> rtl/ndab_ram.sv
// ----------------------------------------------------------------------------
// ndab_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ndab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
